FILE: rtl/core/ksvt_pkg.sv
// Shared types, codes and size helpers for the known slot value table.
`timescale 1ns / 1ps

package ksvt_pkg;

  localparam int KSVT_ENTRIES = 16;

  localparam logic [1:0] MODE_QUERY = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_INVAL = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [2:0] SIZE_NONE = 3'd0;
  localparam logic [2:0] SIZE_1B   = 3'd1;
  localparam logic [2:0] SIZE_2B   = 3'd2;
  localparam logic [2:0] SIZE_4B   = 3'd3;
  localparam logic [2:0] SIZE_8B   = 3'd4;

  typedef enum logic [2:0] {
    OP_QUERY,
    OP_MISS,
    OP_WRITE,
    OP_DROP,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MATCH,
    BK_APPLY
  } bk_state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] byte_offset;
    logic [2:0]  size_code;
    logic [63:0] write_value;
  } req_beat_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] read_value;
    logic        stored;
  } rsp_beat_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] start;
    logic [32:0] end_addr;
    logic [2:0]  code;
    logic [63:0] value;
  } cmd_t;

  // Bytes covered by a size code; zero for none or an unused code.
  function automatic logic [3:0] code_bytes(input logic [2:0] code);
    logic [3:0] b;
    case (code)
      SIZE_1B: b = 4'd1;
      SIZE_2B: b = 4'd2;
      SIZE_4B: b = 4'd4;
      SIZE_8B: b = 4'd8;
      default: b = 4'd0;
    endcase
    return b;
  endfunction

  function automatic logic [63:0] size_mask(input logic [2:0] code);
    logic [63:0] m;
    case (code)
      SIZE_1B: m = 64'h0000_0000_0000_00FF;
      SIZE_2B: m = 64'h0000_0000_0000_FFFF;
      SIZE_4B: m = 64'h0000_0000_FFFF_FFFF;
      SIZE_8B: m = 64'hFFFF_FFFF_FFFF_FFFF;
      default: m = 64'h0;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/core/ksvt_front.sv
// Front end: decode request beats into table commands.
`timescale 1ns / 1ps

module ksvt_front (
  input  ksvt_pkg::req_beat_t req,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic                q_full,
  output logic                push,
  output ksvt_pkg::cmd_t      cmd
);

  logic [3:0] bytes;

  assign bytes     = ksvt_pkg::code_bytes(req.size_code);
  assign req_stall = q_full;
  assign push      = req_valid && !q_full;

  always_comb begin
    cmd.start    = req.byte_offset;
    cmd.end_addr = {1'b0, req.byte_offset} + 33'(bytes);
    cmd.code     = req.size_code;
    cmd.value    = req.write_value & ksvt_pkg::size_mask(req.size_code);
    case (req.mode)
      ksvt_pkg::MODE_QUERY: cmd.op = (bytes == 4'd0) ? ksvt_pkg::OP_MISS : ksvt_pkg::OP_QUERY;
      ksvt_pkg::MODE_WRITE: cmd.op = (bytes == 4'd0) ? ksvt_pkg::OP_CLEAR : ksvt_pkg::OP_WRITE;
      ksvt_pkg::MODE_INVAL: cmd.op = (bytes == 4'd0) ? ksvt_pkg::OP_CLEAR : ksvt_pkg::OP_DROP;
      default:              cmd.op = ksvt_pkg::OP_CLEAR;
    endcase
  end

endmodule

FILE: rtl/core/ksvt_queue.sv
// Two-deep command queue between the front end and the table.
`timescale 1ns / 1ps

module ksvt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ksvt_pkg::cmd_t cmd_in,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output ksvt_pkg::cmd_t cmd_out
);

  ksvt_pkg::cmd_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign cmd_out  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/ksvt_back.sv
// Back end: entry cells, parallel compare, priority pick and result register.
`timescale 1ns / 1ps

module ksvt_back #(
  parameter int ENTRIES = ksvt_pkg::KSVT_ENTRIES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  ksvt_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output ksvt_pkg::rsp_beat_t rsp
);

  ksvt_pkg::bk_state_t state;
  ksvt_pkg::bk_state_t state_next;

  logic [ENTRIES-1:0] valid;
  logic [31:0]        offs [ENTRIES];
  logic [2:0]         code [ENTRIES];
  logic [63:0]        val  [ENTRIES];

  ksvt_pkg::cmd_t     cmd_q;
  logic [ENTRIES-1:0] ov;
  logic [ENTRIES-1:0] ct;
  logic [ENTRIES-1:0] ov_q;
  logic [ENTRIES-1:0] ct_q;

  logic               out_free;
  logic               match_en;
  logic               apply_en;

  logic [ENTRIES-1:0] hit_oh;
  logic [ENTRIES-1:0] free;
  logic [ENTRIES-1:0] free_oh;
  logic [63:0]        sel_val;
  logic [2:0]         sel_off;
  logic [2:0]         byte_dist;
  logic [63:0]        rd_val;

  assign out_free = !(rsp_valid && rsp_stall);

  // Next state
  always_comb begin
    case (state)
      ksvt_pkg::BK_IDLE:  state_next = cmd_valid ? ksvt_pkg::BK_MATCH : ksvt_pkg::BK_IDLE;
      ksvt_pkg::BK_MATCH: state_next = ksvt_pkg::BK_APPLY;
      ksvt_pkg::BK_APPLY: state_next = out_free ? ksvt_pkg::BK_IDLE : ksvt_pkg::BK_APPLY;
      default:            state_next = ksvt_pkg::BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    cmd_pop  = 1'b0;
    match_en = 1'b0;
    apply_en = 1'b0;
    case (state)
      ksvt_pkg::BK_IDLE:  cmd_pop  = cmd_valid;
      ksvt_pkg::BK_MATCH: match_en = 1'b1;
      ksvt_pkg::BK_APPLY: apply_en = out_free;
      default: begin
      end
    endcase
  end

  // Per-cell compare against the command range
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      logic [32:0] es;
      logic [32:0] ee;
      es    = {1'b0, offs[i]};
      ee    = es + 33'(ksvt_pkg::code_bytes(code[i]));
      ov[i] = valid[i] && ({1'b0, cmd_q.start} < ee) && (es < cmd_q.end_addr);
      ct[i] = valid[i] && (es <= {1'b0, cmd_q.start}) && (cmd_q.end_addr <= ee);
    end
  end

  // Lowest containing entry, lowest free entry after dropping overlaps
  assign hit_oh  = ct_q & (~ct_q + ENTRIES'(1));
  assign free    = ~(valid & ~ov_q);
  assign free_oh = free & (~free + ENTRIES'(1));

  always_comb begin
    sel_val = 64'h0;
    sel_off = 3'd0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_oh[i]) begin
        sel_val = sel_val | val[i];
        sel_off = sel_off | offs[i][2:0];
      end
    end
  end

  assign byte_dist = cmd_q.start[2:0] - sel_off;
  assign rd_val    = (sel_val >> {byte_dist, 3'b000}) & ksvt_pkg::size_mask(cmd_q.code);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ksvt_pkg::BK_IDLE;
      valid     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (apply_en) begin
        rsp_valid <= 1'b1;
        case (cmd_q.op)
          ksvt_pkg::OP_CLEAR: valid <= '0;
          ksvt_pkg::OP_DROP:  valid <= valid & ~ov_q;
          ksvt_pkg::OP_WRITE: valid <= (valid & ~ov_q) | free_oh;
          default:            valid <= valid;
        endcase
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_q <= cmd;
    end
    if (match_en) begin
      ov_q <= ov;
      ct_q <= ct;
    end
    if (apply_en) begin
      rsp.hit        <= (cmd_q.op == ksvt_pkg::OP_QUERY) && (|ct_q);
      rsp.read_value <= (cmd_q.op == ksvt_pkg::OP_QUERY) ? rd_val : 64'h0;
      rsp.stored     <= (cmd_q.op == ksvt_pkg::OP_WRITE) && (|free);
    end
  end

  // Fill the chosen free cell on a write
  always_ff @(posedge clk) begin
    if (apply_en && (cmd_q.op == ksvt_pkg::OP_WRITE)) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (free_oh[i]) begin
          offs[i] <= cmd_q.start;
          code[i] <= cmd_q.code;
          val[i]  <= cmd_q.value;
        end
      end
    end
  end

endmodule

FILE: rtl/core/known_slot_value_table_unit.sv
// Top level of the known slot value table: front end, command queue, table back end.
`timescale 1ns / 1ps

//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  req      | req_valid/req_stall  | mode, byte_offset, size_code, write_value
//  rsp      | rsp_valid/rsp_stall  | hit, read_value, stored
//
//  The back end takes one beat at a time through its states idle, match and
//  apply: pop from the queue, compare all entry cells in parallel, then pick by
//  priority, update cells and load the result register; rsp_stall holds apply.
//  The two-deep queue keeps accepting request beats while the back end works
//  or waits on rsp_stall; req_stall rises only when the queue is full.
//  Reset (rst, synchronous) empties the queue, the result register and
//  marks every entry invalid.

module known_slot_value_table_unit #(
  parameter int ENTRIES = ksvt_pkg::KSVT_ENTRIES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  ksvt_pkg::req_beat_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output ksvt_pkg::rsp_beat_t rsp
);

  ksvt_pkg::cmd_t front_cmd;
  ksvt_pkg::cmd_t queue_cmd;
  logic           push;
  logic           q_full;
  logic           q_nonempty;
  logic           pop;

  // Decode mode and size into a table command; zero-size writes and
  // invalidates become clear-all, zero-size queries become a plain miss.
  ksvt_front u_front (
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .q_full    (q_full),
    .push      (push),
    .cmd       (front_cmd)
  );

  // Hold decoded commands so the front and back can stall independently.
  ksvt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .cmd_in   (front_cmd),
    .full     (q_full),
    .pop      (pop),
    .nonempty (q_nonempty),
    .cmd_out  (queue_cmd)
  );

  // Entry cells and result register; the result register parts the table
  // from the consumer so a stalled result blocks only the final step.
  ksvt_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_nonempty),
    .cmd       (queue_cmd),
    .cmd_pop   (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the known slot value table unit.
`timescale 1ns / 1ps

module tb;

  localparam int ENTRIES = ksvt_pkg::KSVT_ENTRIES;
  // Size codes above eight bytes carry no range; use the top one by name.
  localparam logic [2:0] SIZE_RSVD = 3'd7;
  localparam int RANDOM_BEATS = 1350;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 12;
  // Keep both sides busy every cycle while the beat count sits in this band.
  localparam int CALM_LO = 500;
  localparam int CALM_HI = 800;

  logic                clk;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  ksvt_pkg::req_beat_t req = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  ksvt_pkg::rsp_beat_t rsp;

  known_slot_value_table_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the table. Only live entries are ever consulted.
  // ---------------------------------------------------------------------------
  logic [ENTRIES-1:0] kv_live = '0;
  logic [31:0]        kv_off  [ENTRIES] = '{default: '0};
  logic [2:0]         kv_code [ENTRIES] = '{default: '0};
  logic [63:0]        kv_val  [ENTRIES] = '{default: '0};

  ksvt_pkg::req_beat_t beats_to_send [$];  // stimulus not yet presented
  ksvt_pkg::rsp_beat_t due_rsp [$];        // predicted responses, oldest first

  int beats_sent = 0;
  int rsp_seen = 0;
  int mismatches = 0;
  int cycles = 0;

  // Stimulus bookkeeping: the current address window and recent writes,
  // so that lookups can aim inside ranges that are likely still known.
  logic [31:0] win = '0;
  logic [31:0] hist_off [$];
  logic [2:0]  hist_code [$];

  function automatic int unsigned span_bytes(logic [2:0] c);
    case (c)
      ksvt_pkg::SIZE_1B: return 1;
      ksvt_pkg::SIZE_2B: return 2;
      ksvt_pkg::SIZE_4B: return 4;
      ksvt_pkg::SIZE_8B: return 8;
      default: return 0;
    endcase
  endfunction

  function automatic logic [63:0] lane_mask(int unsigned n);
    if (n >= 8) return '1;
    return (64'd1 << (n * 8)) - 64'd1;
  endfunction

  // Drop every live entry whose byte range meets [lo, hi). Ranges end
  // past 2^32 without wrapping, hence the 33-bit bounds.
  function automatic void drop_overlap(logic [32:0] lo, logic [32:0] hi);
    logic [32:0] elo, ehi;
    for (int i = 0; i < ENTRIES; i++) begin
      elo = {1'b0, kv_off[i]};
      ehi = elo + 33'(span_bytes(kv_code[i]));
      if (kv_live[i] && lo < ehi && elo < hi) kv_live[i] = 1'b0;
    end
  endfunction

  // Apply one accepted beat to the shadow table and return its response.
  function automatic ksvt_pkg::rsp_beat_t table_apply(ksvt_pkg::req_beat_t b);
    ksvt_pkg::rsp_beat_t r;
    logic [32:0]         lo, hi, elo, ehi;
    int unsigned         n;
    bit                  found;
    r = '0;
    found = 1'b0;
    n = span_bytes(b.size_code);
    lo = {1'b0, b.byte_offset};
    hi = lo + 33'(n);
    case (b.mode)
      ksvt_pkg::MODE_QUERY: begin
        // Lowest live entry that fully contains the asked range wins.
        if (n != 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            elo = {1'b0, kv_off[i]};
            ehi = elo + 33'(span_bytes(kv_code[i]));
            if (kv_live[i] && !found && elo <= lo && hi <= ehi) begin
              found = 1'b1;
              r.hit = 1'b1;
              r.read_value = (kv_val[i] >> (8 * (lo - elo))) & lane_mask(n);
            end
          end
        end
      end
      ksvt_pkg::MODE_WRITE: begin
        // A zero-size write wipes the table and records nothing.
        if (n == 0) begin
          kv_live = '0;
        end else begin
          drop_overlap(lo, hi);
          // Record in the lowest free entry; a full table drops the write.
          for (int i = 0; i < ENTRIES; i++) begin
            if (!kv_live[i] && !r.stored) begin
              kv_live[i] = 1'b1;
              kv_off[i] = b.byte_offset;
              kv_code[i] = b.size_code;
              kv_val[i] = b.write_value & lane_mask(n);
              r.stored = 1'b1;
            end
          end
        end
      end
      ksvt_pkg::MODE_INVAL: begin
        if (n == 0) kv_live = '0;
        else drop_overlap(lo, hi);
      end
      default: kv_live = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("mismatch at response %0d: %s got %h want %h", rsp_seen, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic queue_beat(logic [1:0] m, logic [31:0] off, logic [2:0] c, logic [63:0] v);
    ksvt_pkg::req_beat_t b;
    b.mode = m;
    b.byte_offset = off;
    b.size_code = c;
    b.write_value = v;
    beats_to_send.push_back(b);
  endtask

  // Write a random-size range and remember it as a lookup target.
  task automatic queue_write(logic [31:0] off);
    logic [2:0] c;
    c = ksvt_pkg::SIZE_1B + 3'($urandom_range(0, 3));
    queue_beat(ksvt_pkg::MODE_WRITE, off, c, {$urandom, $urandom});
    hist_off.push_back(off);
    hist_code.push_back(c);
    if (hist_off.size() > 16) begin
      void'(hist_off.pop_front());
      void'(hist_code.pop_front());
    end
  endtask

  // Look up a sub-range of a recent write, sized no larger than the write, or a window range if none.
  task automatic queue_probe();
    int          k;
    int unsigned espan, qspan;
    logic [2:0]  qc;
    if (hist_off.size() == 0) begin
      queue_beat(ksvt_pkg::MODE_QUERY, win + $urandom_range(0, 63),
                 ksvt_pkg::SIZE_1B + 3'($urandom_range(0, 3)), {$urandom, $urandom});
    end else begin
      k = $urandom_range(0, hist_off.size() - 1);
      espan = span_bytes(hist_code[k]);
      qc = ksvt_pkg::SIZE_1B + 3'($urandom_range(0, hist_code[k] - ksvt_pkg::SIZE_1B));
      qspan = span_bytes(qc);
      queue_beat(ksvt_pkg::MODE_QUERY, hist_off[k] + $urandom_range(0, espan - qspan), qc,
                 {$urandom, $urandom});
    end
  endtask

  task automatic build_directed();
    // Empty table: lookup misses.
    queue_beat(ksvt_pkg::MODE_QUERY, 32'h0, ksvt_pkg::SIZE_1B, '1);
    // Full-width entry at zero, then lookups at every alignment edge.
    queue_beat(ksvt_pkg::MODE_WRITE, 32'h0, ksvt_pkg::SIZE_8B, 64'h0123_4567_89AB_CDEF);
    queue_beat(ksvt_pkg::MODE_QUERY, 32'h0, ksvt_pkg::SIZE_8B, '0);
    queue_beat(ksvt_pkg::MODE_QUERY, 32'h3, ksvt_pkg::SIZE_2B, '0);
    queue_beat(ksvt_pkg::MODE_QUERY, 32'h4, ksvt_pkg::SIZE_4B, '0);
    queue_beat(ksvt_pkg::MODE_QUERY, 32'h7, ksvt_pkg::SIZE_1B, '0);
    // Asked range runs past the entry: miss.
    queue_beat(ksvt_pkg::MODE_QUERY, 32'h6, ksvt_pkg::SIZE_4B, '0);
    // Top of the address space: the range end must not wrap.
    queue_beat(ksvt_pkg::MODE_WRITE, 32'hFFFF_FFF8, ksvt_pkg::SIZE_8B, '1);
    queue_beat(ksvt_pkg::MODE_QUERY, 32'hFFFF_FFFF, ksvt_pkg::SIZE_1B, '0);
    queue_beat(ksvt_pkg::MODE_WRITE, 32'hFFFF_FFFC, ksvt_pkg::SIZE_4B,
               64'hDEAD_BEEF_A5A5_5A5A);
    queue_beat(ksvt_pkg::MODE_QUERY, 32'hFFFF_FFF8, ksvt_pkg::SIZE_8B, '0);
    queue_beat(ksvt_pkg::MODE_QUERY, 32'hFFFF_FFFC, ksvt_pkg::SIZE_4B, '0);
    // Value wider than its size is masked on entry.
    queue_beat(ksvt_pkg::MODE_WRITE, 32'h40, ksvt_pkg::SIZE_1B, '1);
    queue_beat(ksvt_pkg::MODE_QUERY, 32'h40, ksvt_pkg::SIZE_1B, '0);
    queue_beat(ksvt_pkg::MODE_QUERY, 32'h40, ksvt_pkg::SIZE_2B, '0);
    // Overlapping write evicts the older entry at zero.
    queue_beat(ksvt_pkg::MODE_WRITE, 32'h4, ksvt_pkg::SIZE_2B, 64'hFFFF_0000_0000_BEEF);
    queue_beat(ksvt_pkg::MODE_QUERY, 32'h0, ksvt_pkg::SIZE_1B, '0);
    // Invalidate a range, then zero-size query, write and invalidate, and a clear.
    queue_beat(ksvt_pkg::MODE_INVAL, 32'h5, ksvt_pkg::SIZE_1B, '0);
    queue_beat(ksvt_pkg::MODE_QUERY, 32'h4, ksvt_pkg::SIZE_1B, '0);
    queue_beat(ksvt_pkg::MODE_QUERY, 32'h40, ksvt_pkg::SIZE_NONE, '0);
    queue_beat(ksvt_pkg::MODE_WRITE, 32'h80, SIZE_RSVD, '1);
    queue_beat(ksvt_pkg::MODE_QUERY, 32'h40, ksvt_pkg::SIZE_1B, '0);
    queue_beat(ksvt_pkg::MODE_WRITE, 32'h80, ksvt_pkg::SIZE_4B, '1);
    queue_beat(ksvt_pkg::MODE_INVAL, 32'h0, ksvt_pkg::SIZE_NONE, '0);
    queue_beat(ksvt_pkg::MODE_QUERY, 32'h80, ksvt_pkg::SIZE_4B, '0);
    queue_beat(ksvt_pkg::MODE_CLEAR, '1, ksvt_pkg::SIZE_8B, '1);
  endtask

  task automatic build_random();
    int          start_count;
    int unsigned pick;
    logic [31:0] base;
    start_count = beats_to_send.size();
    while (beats_to_send.size() - start_count < RANDOM_BEATS) begin
      // Move the working window now and then, including both ends of memory.
      if ($urandom_range(0, 99) < 3) begin
        case ($urandom_range(0, 3))
          0: win = $urandom;
          1: win = 32'hFFFF_FFC0;
          2: win = '0;
          default: win = $urandom & 32'h0000_FFC0;
        endcase
      end
      pick = $urandom_range(0, 999);
      if (pick < 10) begin
        // Fill the table past capacity with disjoint ranges, then probe.
        queue_beat(ksvt_pkg::MODE_CLEAR, $urandom, 3'($urandom_range(0, 7)),
                   {$urandom, $urandom});
        base = $urandom;
        for (int k = 0; k < 19; k++) queue_write(base + 8 * k);
        for (int k = 0; k < 4; k++) queue_probe();
      end else if (pick < 450) begin
        queue_write(win + $urandom_range(0, 63));
      end else if (pick < 650) begin
        queue_probe();
      end else if (pick < 850) begin
        queue_beat(ksvt_pkg::MODE_QUERY, win + $urandom_range(0, 63),
                   ksvt_pkg::SIZE_1B + 3'($urandom_range(0, 3)), {$urandom, $urandom});
      end else if (pick < 920) begin
        queue_beat(ksvt_pkg::MODE_INVAL, win + $urandom_range(0, 63),
                   ksvt_pkg::SIZE_1B + 3'($urandom_range(0, 3)), {$urandom, $urandom});
      end else if (pick < 940) begin
        queue_beat(ksvt_pkg::MODE_CLEAR, $urandom, 3'($urandom_range(0, 7)),
                   {$urandom, $urandom});
      end else begin
        // Noise: any mode, any offset, any size code including the unused ones.
        queue_beat(2'($urandom_range(0, 3)),
                   $urandom_range(0, 1) ? $urandom : win + $urandom_range(0, 63),
                   3'($urandom_range(0, 7)), {$urandom, $urandom});
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued beats, hold a stalled beat, predict on acceptance.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    bit launch;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        due_rsp.push_back(table_apply(req));
        beats_sent++;
      end
      // Advance only when the slot is free; a stalled beat stays put.
      if (!req_valid || !req_stall) begin
        launch = beats_to_send.size() != 0 &&
                 ((beats_sent >= CALM_LO && beats_sent < CALM_HI) ||
                  $urandom_range(0, 99) >= 31);
        if (launch) req <= beats_to_send.pop_front();
        req_valid <= launch;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted response with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : observe
    ksvt_pkg::rsp_beat_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_seen++;
        if (due_rsp.size() == 0) begin
          report_mismatch("unexpected response, read_value", rsp.read_value, '0);
        end else begin
          want = due_rsp.pop_front();
          if (rsp.hit !== want.hit) report_mismatch("hit", 64'(rsp.hit), 64'(want.hit));
          if (rsp.read_value !== want.read_value)
            report_mismatch("read_value", rsp.read_value, want.read_value);
          if (rsp.stored !== want.stored)
            report_mismatch("stored", 64'(rsp.stored), 64'(want.stored));
        end
      end
      rsp_stall <= !(rsp_seen >= CALM_LO && rsp_seen < CALM_HI) && $urandom_range(0, 99) < 31;
    end
  end

  // Watchdog: a hung handshake or a missing response ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Build the stimulus, release reset, then drain and give the verdict.
  initial begin
    build_directed();
    build_random();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (beats_to_send.size() != 0 || req_valid || due_rsp.size() != 0) @(posedge clk);
    // Let any stray response surface before judging.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
